// ===== sv/assert_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(LBL, CLK, RSTN, PROP, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) PROP) else $error(MSG);

// Expression must never be true outside reset.
`define ASSERT_NEVER(LBL, CLK, RSTN, EXPR, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) !(EXPR)) else $error(MSG);

`endif

// ===== sv/lcdq_pkg.sv =====
package lcdq_pkg;

    // Display geometry
    localparam int LINE_LEN = 16;
    localparam int LINE_IW  = 4;
    localparam int POS_W    = 5;

    typedef logic [LINE_LEN-1:0][7:0] line_t;

    // Request kinds carried on tuser
    localparam logic CMD_PRINT = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Display and expander constants
    localparam logic [7:0] SPACE_CHAR    = 8'h20;
    localparam logic [7:0] CURSOR_ROW0   = 8'h80;
    localparam logic [7:0] CURSOR_ROW1   = 8'hC0;
    localparam logic [7:0] RESET_ADDRESS = 8'h4E;
    localparam logic       BACKLIGHT_ON  = 1'b1;
    localparam logic [1:0] LAST_BEAT     = 2'd3;

    // Stream widths
    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 16;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic commit;
        logic take_slot;
        logic load_cursor;
        logic load_char;
        logic beat_advance;
    } lcdq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic slot_any;
        logic line_done;
        logic last_beat;
    } lcdq_stat_t;

endpackage

// ===== sv/lcdq_dp.sv =====
module lcdq_dp
    import lcdq_pkg::*;
#(
    parameter int QUEUE_SLOTS = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  lcdq_cmd_t   cmd,
    output lcdq_stat_t  stat,
    input  logic        cfg_write,
    input  logic [7:0]  cfg_data,
    input  logic        in_row,
    input  logic [4:0]  in_text_length,
    input  logic [63:0] in_chars_low,
    input  logic [63:0] in_chars_high,
    output logic [7:0]  bus_address,
    output logic [7:0]  bus_byte,
    output logic        last_byte
);

    localparam int SLOT_IW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;

    logic [7:0]               addr_reg;
    line_t                    line_reg;
    logic                     row_reg;
    line_t [1:0]              shadow_reg;
    line_t                    slot_text_mem [QUEUE_SLOTS];
    logic [QUEUE_SLOTS-1:0]   slot_valid_reg;
    logic [QUEUE_SLOTS-1:0]   slot_row_reg;
    line_t                    work_line_reg;
    logic                     work_row_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [7:0]               disp_byte_reg;
    logic                     is_data_reg;
    logic [1:0]               beat_reg;

    line_t                    line_in;
    logic [2*64-1:0]          chars_all;
    logic                     line_differs;
    logic                     free_any;
    logic [SLOT_IW-1:0]       free_idx;
    logic                     take_any;
    logic [SLOT_IW-1:0]       take_idx;
    logic [3:0]               nibble;

    // Pad the incoming text with spaces past its length
    always_comb
    begin
        chars_all = {in_chars_high, in_chars_low};
        for (int i = 0; i < LINE_LEN; i++)
        begin
            line_in[i] = (POS_W'(i) < in_text_length) ? chars_all[8*i +: 8] : SPACE_CHAR;
        end
    end

    // Find the lowest free slot and the lowest queued slot
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        take_any = 1'b0;
        take_idx = '0;
        for (int i = QUEUE_SLOTS - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = SLOT_IW'(i);
            end
            if (slot_valid_reg[i])
            begin
                take_any = 1'b1;
                take_idx = SLOT_IW'(i);
            end
        end
    end

    assign line_differs = (shadow_reg[row_reg] != line_reg);

    // Address register and request capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= RESET_ADDRESS;
        end
        else if (cfg_write)
        begin
            addr_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            line_reg <= line_in;
            row_reg  <= in_row;
        end
    end

    // Shadow copies and slot bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_reg     <= '0;
            slot_valid_reg <= '0;
            work_row_reg   <= 1'b0;
            pos_reg        <= '0;
            beat_reg       <= '0;
        end
        else
        begin
            if (cmd.commit && line_differs)
            begin
                shadow_reg[row_reg] <= line_reg;
                if (free_any)
                begin
                    slot_valid_reg[free_idx] <= 1'b1;
                end
            end
            if (cmd.take_slot)
            begin
                slot_valid_reg[take_idx] <= 1'b0;
                work_row_reg             <= slot_row_reg[take_idx];
                pos_reg                  <= '0;
            end
            if (cmd.load_cursor || cmd.load_char)
            begin
                beat_reg <= '0;
            end
            else if (cmd.beat_advance)
            begin
                beat_reg <= beat_reg + 2'd1;
            end
            if (cmd.load_char)
            begin
                pos_reg <= pos_reg + POS_W'(1);
            end
        end
    end

    // Slot memory: write on commit, registered read into the working line
    always_ff @(posedge clk)
    begin
        if (cmd.commit && line_differs && free_any)
        begin
            slot_text_mem[free_idx] <= line_reg;
            slot_row_reg[free_idx]  <= row_reg;
        end
        if (cmd.take_slot)
        begin
            work_line_reg <= slot_text_mem[take_idx];
        end
    end

    // Load the display byte for the next transfer
    always_ff @(posedge clk)
    begin
        if (cmd.load_cursor)
        begin
            disp_byte_reg <= work_row_reg ? CURSOR_ROW1 : CURSOR_ROW0;
            is_data_reg   <= 1'b0;
        end
        else if (cmd.load_char)
        begin
            disp_byte_reg <= work_line_reg[pos_reg[LINE_IW-1:0]];
            is_data_reg   <= 1'b1;
        end
    end

    // Expander byte: high nibble first, enable high on even beats
    assign nibble      = beat_reg[1] ? disp_byte_reg[3:0] : disp_byte_reg[7:4];
    assign bus_byte    = {nibble, BACKLIGHT_ON, ~beat_reg[0], 1'b0, is_data_reg};
    assign bus_address = addr_reg;
    assign last_byte   = (beat_reg == LAST_BEAT);

    assign stat.slot_any  = take_any;
    assign stat.line_done = pos_reg[POS_W-1];
    assign stat.last_beat = (beat_reg == LAST_BEAT);

endmodule

// ===== sv/lcdq_ctrl.sv =====
module lcdq_ctrl
    import lcdq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_command,
    output logic       in_ready,
    output logic       cfg_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  lcdq_stat_t stat,
    output lcdq_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PRINT,
        S_TICK,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CURSOR,
        PH_PRINT
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    // Sequence requests and the display phase
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        cfg_ready  = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cfg_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (in_command == CMD_TICK) ? S_TICK : S_PRINT;
                end
            end
            S_PRINT:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            S_TICK:
            begin
                state_next = S_IDLE;
                unique case (phase_reg)
                    PH_CURSOR:
                    begin
                        cmd.load_cursor = 1'b1;
                        phase_next      = PH_PRINT;
                        state_next      = S_EMIT;
                    end
                    PH_PRINT:
                    begin
                        if (!stat.line_done)
                        begin
                            cmd.load_char = 1'b1;
                            state_next    = S_EMIT;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        if (stat.slot_any)
                        begin
                            cmd.take_slot = 1'b1;
                            phase_next    = PH_CURSOR;
                        end
                    end
                endcase
            end
            S_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.beat_advance = 1'b1;
                    if (stat.last_beat)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== sv/lcd_line_update_queue_top.sv =====
// Character display line writer for a two-row, 16-column display behind a 4-bit
// expander. Print requests (tuser low) are space-padded, compared with the row's
// shadow copy and, when changed, queued in the lowest free of QUEUE_SLOTS slots
// (dropped when all are full, shadow still updated). Tick requests (tuser high)
// step the display sequencer: from idle a tick loads the next queued line, then
// one tick sends the cursor command and each later tick one character, each as
// four bus bytes with tlast on the fourth; one further tick returns to idle.
// Requests are handled one at a time, each through the controller's accept and
// execute states; a tick with output then holds in the emit state for its four
// output beats, driven from the one-byte output register, until the sink takes
// the last. No clearing pass runs after reset. The address register is written
// only while idle.
module lcd_line_update_queue_top
    import lcdq_pkg::*;
#(
    parameter int QUEUE_SLOTS = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // row[0], text_length[5:1], chars_low[69:6], chars_high[133:70], zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // command[0]
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // bus_address[7:0], bus_byte[15:8]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [7:0]             cfg_data
);

    lcdq_cmd_t  cmd;
    lcdq_stat_t stat;
    logic [7:0] bus_address;
    logic [7:0] bus_byte;

    lcdq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_command (s_axis_tuser),
        .in_ready   (s_axis_tready),
        .cfg_ready  (cfg_ready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .stat       (stat),
        .cmd        (cmd)
    );

    lcdq_dp #(
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_write      (cfg_valid && cfg_ready),
        .cfg_data       (cfg_data),
        .in_row         (s_axis_tdata[0]),
        .in_text_length (s_axis_tdata[5:1]),
        .in_chars_low   (s_axis_tdata[69:6]),
        .in_chars_high  (s_axis_tdata[133:70]),
        .bus_address    (bus_address),
        .bus_byte       (bus_byte),
        .last_byte      (m_axis_tlast)
    );

    assign m_axis_tdata = {bus_byte, bus_address};

endmodule

// ===== sv/lcdq_checker.sv =====
`include "assert_macros.svh"

module lcdq_checker
    import lcdq_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast,
    input logic                   cfg_ready
);

    // No new request and no address write while a transfer is on the bus
    `ASSERT_NEVER(a_no_accept_in_emit, clk, rst_n, (s_axis_tready || cfg_ready) && m_axis_tvalid, "request taken during transfer")

    // Hold the bus beat while the sink stalls
    `ASSERT_CLK(a_hold_on_stall, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast), "beat changed under stall")

    // Drop valid once the closing beat is taken
    `ASSERT_CLK(a_end_after_last, clk, rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid, "transfer ran past last beat")

    // Closing beat has enable low and backlight on
    `ASSERT_CLK(a_last_enable_low, clk, rst_n, m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[10] && m_axis_tdata[11], "bad closing beat")

endmodule

bind lcd_line_update_queue_top lcdq_checker u_lcdq_checker (.*);

// ===== tb/sv/tb_lcd_line_update_queue_top.sv =====
`timescale 1ns / 1ps

module tb_lcd_line_update_queue_top;
    import lcdq_pkg::*;

    localparam int SLOTS         = 2;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 300;

    // Expander nibble framing: enable high / low, command or data register
    localparam logic [7:0] CMD_STROBE_HI = 8'h0C;
    localparam logic [7:0] CMD_STROBE_LO = 8'h08;
    localparam logic [7:0] DAT_STROBE_HI = 8'h0D;
    localparam logic [7:0] DAT_STROBE_LO = 8'h09;

    typedef enum logic [1:0] {SEQ_IDLE, SEQ_CURSOR, SEQ_PRINT} seq_phase_t;

    typedef struct packed {
        logic        cmd;
        logic        row;
        logic [4:0]  len;
        logic [63:0] lo;
        logic [63:0] hi;
    } disp_req_t;

    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] data;
        logic       is_last;
    } bus_beat_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [7:0]             cfg_data = 8'h00;

    // Stimulus and checking state
    disp_req_t pending_reqs[$];
    disp_req_t drv_req;
    disp_req_t last_print [2];
    bus_beat_t bus_beats_due[$];
    int        tx_idle_pct = 32;
    int        rx_idle_pct = 45;
    logic      hold_req = 1'b0;
    logic      hold_taken = 1'b0;
    int        rx_hold_left = 0;
    int        err_count = 0;
    int        cycle_count = 0;

    // Display model state
    logic [7:0] bus_addr_reg = RESET_ADDRESS;
    line_t      shadow_line [2] = '{default: '0};
    line_t      slot_line [SLOTS];
    logic       slot_busy [SLOTS] = '{default: 1'b0};
    logic       slot_row_q [SLOTS];
    seq_phase_t seq_phase = SEQ_IDLE;
    logic       work_row_q = 1'b0;
    int         char_pos = 0;
    line_t      work_line_q;

    lcd_line_update_queue_top #(
        .QUEUE_SLOTS (SLOTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // Queue the four expander beats of one display byte
    task automatic push_byte_beats(input logic [7:0] b, input logic is_data);
        bus_beat_t  beat;
        logic [3:0] nib;
        for (int k = 0; k < 4; k++)
        begin
            nib          = (k < 2) ? b[7:4] : b[3:0];
            beat.addr    = bus_addr_reg;
            beat.data[7:4] = nib;
            if (k % 2 == 0)
                beat.data[3:0] = is_data ? DAT_STROBE_HI[3:0] : CMD_STROBE_HI[3:0];
            else
                beat.data[3:0] = is_data ? DAT_STROBE_LO[3:0] : CMD_STROBE_LO[3:0];
            beat.is_last = (k == 3);
            bus_beats_due.push_back(beat);
        end
    endtask

    // Advance the display model by one accepted request
    task automatic predict_display(input disp_req_t r);
        line_t line;
        int    n;
        bit    done;
        done = 1'b0;
        if (r.cmd == CMD_PRINT)
        begin
            n = (r.len > LINE_LEN) ? LINE_LEN : r.len;
            for (int i = 0; i < LINE_LEN; i++)
            begin
                if (i >= n)
                    line[i] = SPACE_CHAR;
                else if (i < 8)
                    line[i] = r.lo[i*8 +: 8];
                else
                    line[i] = r.hi[(i-8)*8 +: 8];
            end
            if (line != shadow_line[r.row])
            begin
                // shadow follows every change, even when the queue is full
                shadow_line[r.row] = line;
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (!done && !slot_busy[s])
                    begin
                        slot_line[s]  = line;
                        slot_row_q[s] = r.row;
                        slot_busy[s]  = 1'b1;
                        done = 1'b1;
                    end
                end
            end
        end
        else
        begin
            case (seq_phase)
                SEQ_CURSOR:
                begin
                    push_byte_beats(work_row_q ? CURSOR_ROW1 : CURSOR_ROW0, 1'b0);
                    seq_phase = SEQ_PRINT;
                end
                SEQ_PRINT:
                begin
                    if (char_pos < LINE_LEN)
                    begin
                        push_byte_beats(work_line_q[char_pos], 1'b1);
                        char_pos++;
                    end
                    else
                        seq_phase = SEQ_IDLE;
                end
                default:
                begin
                    // load the lowest queued line, if any
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        if (!done && slot_busy[s])
                        begin
                            work_line_q  = slot_line[s];
                            work_row_q   = slot_row_q[s];
                            char_pos     = 0;
                            seq_phase    = SEQ_CURSOR;
                            slot_busy[s] = 1'b0;
                            done = 1'b1;
                        end
                    end
                end
            endcase
        end
    endtask

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("[%0t] mismatch on %s: got %02h, want %02h", $realtime, field, got, want);
        err_count++;
    endtask

    task automatic queue_print(input disp_req_t r);
        r.cmd = CMD_PRINT;
        pending_reqs.push_back(r);
        last_print[r.row] = r;
    endtask

    task automatic queue_ticks(input int n);
        disp_req_t r;
        for (int i = 0; i < n; i++)
        begin
            // payload of a tick is ignored, so fill it with noise
            r.cmd = CMD_TICK;
            r.row = 1'($urandom_range(0, 1));
            r.len = 5'($urandom_range(0, 31));
            r.lo  = {$urandom, $urandom};
            r.hi  = {$urandom, $urandom};
            pending_reqs.push_back(r);
        end
    endtask

    // Mix of print requests and tick bursts, enough ticks to keep lines flowing
    task automatic queue_random_phase(input int target);
        disp_req_t r;
        int        n;
        int        pick;
        int        burst;
        n = 0;
        while (n < target)
        begin
            if ($urandom_range(0, 99) < 40)
            begin
                pick = $urandom_range(0, 99);
                r.row = 1'($urandom_range(0, 1));
                if (pick < 20)
                begin
                    // repeat of the row's current text: no change expected
                    r = last_print[r.row];
                    if (r.len >= LINE_LEN)
                        r.len = 5'(LINE_LEN + $urandom_range(0, 15));
                end
                else
                begin
                    r.len = (pick < 30) ? 5'($urandom_range(17, 31))
                                        : 5'($urandom_range(0, LINE_LEN));
                    r.lo  = {$urandom, $urandom};
                    r.hi  = {$urandom, $urandom};
                end
                queue_print(r);
                n++;
            end
            else
            begin
                burst = $urandom_range(1, 20);
                queue_ticks(burst);
                n += burst;
            end
        end
    endtask

    // Hold off until every request is taken and every beat has arrived
    task automatic drain_and_settle();
        @(negedge clk);
        while (pending_reqs.size() != 0 || s_axis_tvalid)
            @(negedge clk);
        while (bus_beats_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_address(input logic [7:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        bus_addr_reg = value;
        @(negedge clk);
    endtask

    // Sender: predict on acceptance, then offer the next pending request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_display(drv_req);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    drv_req = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= drv_req.cmd;
                    s_axis_tdata  <= {2'b00, drv_req.hi, drv_req.lo, drv_req.len, drv_req.row};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken    <= 1'b1;
            rx_hold_left  <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else if (rx_hold_left > 0)
        begin
            rx_hold_left  <= rx_hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Check each output beat against the oldest expectation
    always @(posedge clk)
    begin
        bus_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (bus_beats_due.size() == 0)
                report_mismatch("unexpected beat", m_axis_tdata[15:8], 8'h00);
            else
            begin
                want = bus_beats_due.pop_front();
                if (m_axis_tdata[7:0] !== want.addr)
                    report_mismatch("bus_address", m_axis_tdata[7:0], want.addr);
                if (m_axis_tdata[15:8] !== want.data)
                    report_mismatch("bus_byte", m_axis_tdata[15:8], want.data);
                if (m_axis_tlast !== want.is_last)
                    report_mismatch("last_byte", {7'd0, m_axis_tlast}, {7'd0, want.is_last});
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        disp_req_t r;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty tick, padding, zero bytes, long length, full queue,
        // unchanged line, print while busy; reset address in use
        queue_ticks(1);
        r.row = 1'b0; r.len = 5'd0; r.lo = {$urandom, $urandom}; r.hi = {$urandom, $urandom};
        queue_print(r);
        r.row = 1'b1; r.len = 5'd31; r.lo = 64'h0; r.hi = '1;
        queue_print(r);
        r.row = 1'b0; r.len = 5'd5; r.lo = 64'h0000_006F_6C6C_6548; r.hi = 64'h0;
        queue_print(r);
        queue_print(r);
        r.row = 1'b1; r.len = 5'd16; r.lo = '1; r.hi = '1;
        queue_print(r);
        queue_ticks(3);
        r.row = 1'b0; r.len = 5'd16; r.lo = 64'h0123_4567_89AB_CDEF; r.hi = 64'hFEDC_BA98_7654_3210;
        queue_print(r);
        queue_ticks(17);
        drain_and_settle();

        write_address(8'h00);
        queue_random_phase(150);
        drain_and_settle();

        tx_idle_pct = 45;
        rx_idle_pct = 32;
        write_address(8'hFF);
        queue_random_phase(150);
        drain_and_settle();

        // No idling, one long receiver stall to back the block up
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_address(8'($urandom_range(1, 254)));
        queue_random_phase(145);
        hold_req = 1'b1;
        drain_and_settle();

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
